### rtl/oal_pkg.sv
package oal_pkg;

    localparam int CAPACITY = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;
    localparam int OP_W     = 4;
    localparam int ST_W     = 2;

    localparam logic [OP_W-1:0] OP_INS_AT    = 4'd0;
    localparam logic [OP_W-1:0] OP_INS_FIRST = 4'd1;
    localparam logic [OP_W-1:0] OP_INS_LAST  = 4'd2;
    localparam logic [OP_W-1:0] OP_DEL_AT    = 4'd3;
    localparam logic [OP_W-1:0] OP_DEL_FIRST = 4'd4;
    localparam logic [OP_W-1:0] OP_DEL_LAST  = 4'd5;
    localparam logic [OP_W-1:0] OP_FIND      = 4'd6;
    localparam logic [OP_W-1:0] OP_READ      = 4'd7;
    localparam logic [OP_W-1:0] OP_CLEAR     = 4'd8;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_BADPOS   = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL     = 2'd2;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd3;

    // Broadcast to every cell of the row
    typedef struct packed {
        logic                    ins;
        logic                    del;
        logic [IDX_W-1:0]        pos;
        logic signed [VAL_W-1:0] value;
        logic [CNT_W-1:0]        count;
    } t_cell_ctrl;

endpackage

### rtl/oal_req_if.sv
interface oal_req_if;
    logic                                   valid;
    logic                                   ready;
    logic [oal_pkg::OP_W-1:0]               opcode;
    logic [oal_pkg::CNT_W-1:0]              position;
    logic signed [oal_pkg::VAL_W-1:0]       value;

    modport source (output valid, opcode, position, value, input ready);
    modport sink   (input valid, opcode, position, value, output ready);
endinterface

### rtl/oal_rsp_if.sv
interface oal_rsp_if;
    logic                                   valid;
    logic                                   ready;
    logic [oal_pkg::ST_W-1:0]               status;
    logic [oal_pkg::IDX_W-1:0]              index;
    logic signed [oal_pkg::VAL_W-1:0]       read_value;
    logic [oal_pkg::CNT_W-1:0]              count;

    modport source (output valid, status, index, read_value, count, input ready);
    modport sink   (input valid, status, index, read_value, count, output ready);
endinterface

### rtl/ordered_array_list_engine_top.sv
// Bounded ordered list of signed 32-bit entries, one operation per request.
// i_req (sink): opcode, position, value. o_rsp (source): status, index,
// read_value and count after the operation. A transfer happens on a clock
// edge with valid and ready both high.
// Each entry lives in one cell of a row of 32; insert and delete shift the
// cells above the position by one place, and find compares all cells at
// once and takes the lowest match.
// The response is registered and appears in the cycle after the request
// transfer. One request per cycle is taken while the receiver takes each
// response.
// If the receiver stalls, the response is held and a new request is taken
// only in the cycle that the held response is transferred.
// Reset (i_rst_n low, synchronous) empties the list and drops any pending
// response; entry contents are not cleared and are only read once written.
module ordered_array_list_engine_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    oal_req_if.sink     i_req,
    oal_rsp_if.source   o_rsp
);

    localparam int N = oal_pkg::CAPACITY;

    logic [oal_pkg::CNT_W-1:0]            r_count;
    logic [oal_pkg::CNT_W-1:0]            n_count;
    logic                                 r_out_valid;
    logic [oal_pkg::ST_W-1:0]             r_status;
    logic [oal_pkg::IDX_W-1:0]            r_index;
    logic signed [oal_pkg::VAL_W-1:0]     r_read_value;

    logic                                 w_accept;
    logic [oal_pkg::CNT_W-1:0]            w_pos;
    logic                                 w_is_ins;
    logic                                 w_is_del;
    logic [oal_pkg::ST_W-1:0]             w_status;
    logic [oal_pkg::IDX_W-1:0]            w_index;
    logic signed [oal_pkg::VAL_W-1:0]     w_read_value;
    logic                                 w_found;
    logic [oal_pkg::IDX_W-1:0]            w_match_idx;
    oal_pkg::t_cell_ctrl                  w_ctrl;

    logic signed [oal_pkg::VAL_W-1:0]     w_data [N];
    logic [N-1:0]                         w_match;

    assign w_accept    = i_req.valid && i_req.ready;
    assign i_req.ready = !r_out_valid || o_rsp.ready;

    // Effective position per opcode
    always_comb begin
        w_is_ins = 1'b0;
        w_is_del = 1'b0;
        w_pos    = i_req.position;
        unique case (i_req.opcode)
            oal_pkg::OP_INS_AT: begin
                w_is_ins = 1'b1;
            end
            oal_pkg::OP_INS_FIRST: begin
                w_is_ins = 1'b1;
                w_pos    = '0;
            end
            oal_pkg::OP_INS_LAST: begin
                w_is_ins = 1'b1;
                w_pos    = r_count;
            end
            oal_pkg::OP_DEL_AT: begin
                w_is_del = 1'b1;
            end
            oal_pkg::OP_DEL_FIRST: begin
                w_is_del = 1'b1;
                w_pos    = '0;
            end
            oal_pkg::OP_DEL_LAST: begin
                w_is_del = 1'b1;
                w_pos    = r_count - oal_pkg::CNT_W'(1);
            end
            default: begin
            end
        endcase
    end

    // Lowest matching cell
    always_comb begin
        w_found     = |w_match;
        w_match_idx = '0;
        for (int k = N - 1; k >= 0; k--) begin
            if (w_match[k]) begin
                w_match_idx = oal_pkg::IDX_W'(k);
            end
        end
    end

    always_comb begin
        w_status     = oal_pkg::ST_OK;
        w_index      = '0;
        w_read_value = '0;
        n_count      = r_count;
        w_ctrl.ins   = 1'b0;
        w_ctrl.del   = 1'b0;
        w_ctrl.pos   = w_pos[oal_pkg::IDX_W-1:0];
        w_ctrl.value = i_req.value;
        w_ctrl.count = r_count;
        if (w_is_ins) begin
            priority if (w_pos > r_count) begin
                w_status = oal_pkg::ST_BADPOS;
            end else if (r_count >= oal_pkg::CNT_W'(N)) begin
                w_status = oal_pkg::ST_FULL;
            end else begin
                w_ctrl.ins = w_accept;
                n_count    = r_count + oal_pkg::CNT_W'(1);
            end
        end else if (w_is_del) begin
            if (w_pos >= r_count) begin
                w_status = oal_pkg::ST_BADPOS;
            end else begin
                w_ctrl.del = w_accept;
                n_count    = r_count - oal_pkg::CNT_W'(1);
            end
        end else if (i_req.opcode == oal_pkg::OP_FIND) begin
            if (w_found) begin
                w_index = w_match_idx;
            end else begin
                w_status = oal_pkg::ST_NOTFOUND;
            end
        end else if (i_req.opcode == oal_pkg::OP_READ) begin
            if (w_pos >= r_count) begin
                w_status = oal_pkg::ST_BADPOS;
            end else begin
                w_read_value = w_data[w_pos[oal_pkg::IDX_W-1:0]];
            end
        end else if (i_req.opcode == oal_pkg::OP_CLEAR) begin
            n_count = '0;
        end
    end

    for (genvar g = 0; g < N; g++) begin : g_cell
        logic signed [oal_pkg::VAL_W-1:0] w_left;
        logic signed [oal_pkg::VAL_W-1:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = i_req.value;
        end else begin : g_mid_l
            assign w_left = w_data[g-1];
        end
        if (g == N - 1) begin : g_last
            assign w_right = w_data[g];
        end else begin : g_mid_r
            assign w_right = w_data[g+1];
        end
        oal_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_idx   (oal_pkg::IDX_W'(g)),
            .i_left  (w_left),
            .i_right (w_right),
            .o_data  (w_data[g]),
            .o_match (w_match[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status     <= w_status;
            r_index      <= w_index;
            r_read_value <= w_read_value;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_status;
    assign o_rsp.index      = r_index;
    assign o_rsp.read_value = r_read_value;
    assign o_rsp.count      = r_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= oal_pkg::CNT_W'(N))
        else $error("count above capacity");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_req.opcode == oal_pkg::OP_CLEAR) |=> (r_count == '0))
        else $error("clear left entries");

    a_ins_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_is_ins && w_status == oal_pkg::ST_OK)
        |=> (r_count == $past(r_count) + oal_pkg::CNT_W'(1)))
        else $error("insert did not grow count");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_rsp.ready) |=> (r_out_valid && $stable(r_status)))
        else $error("stalled response lost");

    a_notfound_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status != oal_pkg::ST_OK) |-> (r_index == '0))
        else $error("index set on failure");

endmodule

### rtl/oal_cell.sv
module oal_cell (
    input  logic                                i_clk,
    input  oal_pkg::t_cell_ctrl                 i_ctrl,
    input  logic [oal_pkg::IDX_W-1:0]           i_idx,
    input  logic signed [oal_pkg::VAL_W-1:0]    i_left,
    input  logic signed [oal_pkg::VAL_W-1:0]    i_right,
    output logic signed [oal_pkg::VAL_W-1:0]    o_data,
    output logic                                o_match
);

    logic signed [oal_pkg::VAL_W-1:0] r_data;
    logic signed [oal_pkg::VAL_W-1:0] n_data;

    always_comb begin
        priority if (i_ctrl.ins && (i_idx == i_ctrl.pos)) begin
            n_data = i_ctrl.value;
        end else if (i_ctrl.ins && (i_idx > i_ctrl.pos)) begin
            n_data = i_left;
        end else if (i_ctrl.del && (i_idx >= i_ctrl.pos)) begin
            n_data = i_right;
        end else begin
            n_data = r_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data  = r_data;
    assign o_match = (r_data == i_ctrl.value) && ({1'b0, i_idx} < i_ctrl.count);

endmodule
